// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked implication checks with synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// File: src/fce_pkg.sv
// ---------------------------------------------------------------------------
// fce_pkg
// Shared types and constants of the framed checksum encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fce_pkg;

  localparam int ACC_W      = 64;
  localparam int WORD_W     = 32;
  localparam int HEADER_LEN = 5;

  // Header bytes (all below 0x80, so their signed and unsigned values agree)
  localparam logic [7:0] MAGIC_A       = 8'h4D;
  localparam logic [7:0] MAGIC_B       = 8'h53;
  localparam logic [7:0] FRAME_VERSION = 8'h01;
  localparam logic [7:0] FRAME_TYPE    = 8'h01;

  // Result kind codes
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_CHECK   = 2'd2;

  // One accepted input transaction, classified against the frame state
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic       start;   // opens a frame: five header bytes first
    logic       pay;     // carries a payload byte
    logic       ends;    // closes the frame: eight checksum bytes last
  } item_t;

  // Item plus the accumulator value after it has been absorbed
  typedef struct packed {
    item_t              item;
    logic [ACC_W-1:0]   acc;
  } acc_item_t;

endpackage

// File: src/fce_if.sv
// ---------------------------------------------------------------------------
// fce_if
// Valid/ready stream interfaces for the encoder input and result channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [7:0] payload_length;

  modport source (output valid, payload_byte, payload_length, input ready);
  modport sink   (input valid, payload_byte, payload_length, output ready);
endinterface

interface fce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, out_byte, out_kind, run_last, frame_end, input ready);
  modport sink   (input valid, out_byte, out_kind, run_last, frame_end, output ready);
endinterface

// File: src/framed_checksum_encoder.sv
// An accepted transaction passes the input register, both accumulator stages
// and the result register before its first result is offered. Throughput:
// one result per cycle unless the sink stalls; the output byte sequencer gives
// a transaction 1 result mid-frame, 6 at frame start, 9 at frame end and 13 or
// 14 for a one-transaction frame; mid-frame transactions flow one per cycle too.
// Reset: synchronous, active low; clears all valids and the frame state.
// ---------------------------------------------------------------------------
// framed_checksum_encoder
// Wraps payload bytes into frames with a header and an 8-byte checksum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_checksum_encoder (
  input  logic       clk,
  input  logic       rst_n,
  fce_in_if.sink     in_chan,
  fce_out_if.source  out_chan
);

  logic               s1_valid, s1_ready;
  fce_pkg::item_t     s1_item;
  logic               s3_valid, s3_ready;
  fce_pkg::acc_item_t s3_data;

  // Frame tracking and input register
  fce_frame_ctl u_frame_ctl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_chan.valid),
    .in_ready          (in_chan.ready),
    .in_payload_byte   (in_chan.payload_byte),
    .in_payload_length (in_chan.payload_length),
    .dn_valid          (s1_valid),
    .dn_ready          (s1_ready),
    .dn_item           (s1_item)
  );

  // Accumulator datapath
  fce_checksum u_checksum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_item  (s1_item),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  // Result register and byte sequencer
  fce_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s3_valid),
    .up_ready  (s3_ready),
    .up_data   (s3_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.out_byte),
    .out_kind  (out_chan.out_kind),
    .run_last  (out_chan.run_last),
    .frame_end (out_chan.frame_end)
  );

endmodule

// File: src/fce_frame_ctl.sv
// ---------------------------------------------------------------------------
// fce_frame_ctl
// Input register and frame tracking: classifies each transaction as frame
// start, payload and/or frame end and keeps the remaining byte count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fce_frame_ctl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_payload_byte,
  input  logic [7:0]    in_payload_length,
  output logic          dn_valid,
  input  logic          dn_ready,
  output fce_pkg::item_t dn_item
);

  logic           in_frame_r, in_frame_nxt;
  logic [7:0]     remain_r, remain_nxt;
  logic           valid_r;
  fce_pkg::item_t item_r, item_nxt;
  logic           accept;

  assign in_ready = !valid_r || dn_ready;
  assign accept   = in_valid && in_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  // Classify the incoming transaction and advance the frame state
  always_comb begin
    item_nxt.payload_byte   = in_payload_byte;
    item_nxt.payload_length = in_payload_length;
    item_nxt.start          = !in_frame_r;
    if (!in_frame_r) begin
      item_nxt.pay = (in_payload_length != 8'd0);
      item_nxt.ends = (in_payload_length[7:1] == 7'd0);   // length 0 or 1
      remain_nxt = item_nxt.ends ? 8'd0 : in_payload_length - 8'd1;
    end else begin
      item_nxt.pay  = 1'b1;
      item_nxt.ends = (remain_r == 8'd1);
      remain_nxt    = remain_r - 8'd1;
    end
    in_frame_nxt = !item_nxt.ends;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      in_frame_r <= 1'b0;
      remain_r   <= 8'd0;
    end else begin
      if (accept) begin
        valid_r    <= 1'b1;
        in_frame_r <= in_frame_nxt;
        remain_r   <= remain_nxt;
      end else if (dn_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Item register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: src/fce_checksum.sv
// ---------------------------------------------------------------------------
// fce_checksum
// Two-stage accumulator datapath. Stage one folds the four constant header
// bytes and the length byte into a start value; stage two absorbs the
// payload byte into the running 64-bit accumulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fce_checksum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  fce_pkg::item_t     up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output fce_pkg::acc_item_t dn_data
);

  // The four fixed header bytes turn start value len+5 into GAIN*len + BASE
  localparam int FA       = int'(fce_pkg::MAGIC_A) + 1;
  localparam int FB       = int'(fce_pkg::MAGIC_B) + 1;
  localparam int FV       = int'(fce_pkg::FRAME_VERSION) + 1;
  localparam int FT       = int'(fce_pkg::FRAME_TYPE) + 1;
  localparam int HDR_GAIN = FA * FB * FV * FT;
  localparam int HDR_B1   = (fce_pkg::HEADER_LEN + FA) * FA;
  localparam int HDR_B2   = (HDR_B1 + FB) * FB;
  localparam int HDR_B3   = (HDR_B2 + FV) * FV;
  localparam int HDR_BASE = (HDR_B3 + FT) * FT;
  localparam int POLY_W   = 24;   // GAIN*255 + BASE stays below 2^24
  localparam int HSUM_W   = POLY_W + 2;
  localparam int HACC_W   = HSUM_W + 10;
  localparam int ACC_W    = fce_pkg::ACC_W;

  logic                     v2_r, v3_r;
  logic                     s2_take, s3_take;
  fce_pkg::item_t           item2_r, item3_r;
  logic signed [HACC_W-1:0] hacc_r, hacc_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;

  logic [POLY_W-1:0]        hpoly;
  logic signed [9:0]        flen;
  logic signed [HSUM_W-1:0] hsum;

  logic [ACC_W-1:0]         base, sum, prod;
  logic signed [9:0]        fpay;
  logic [7:0]               fmag;
  logic                     fneg;

  assign s3_take  = !v3_r || dn_ready;
  assign s2_take  = !v2_r || s3_take;
  assign up_ready = s2_take;
  assign dn_valid = v3_r;
  assign dn_data  = '{item: item3_r, acc: acc_r};

  // Stage one: absorb the length header byte into the header polynomial
  always_comb begin
    hpoly    = POLY_W'(HDR_GAIN) * POLY_W'(up_item.payload_length)
               + POLY_W'(HDR_BASE);
    flen     = $signed({{2{up_item.payload_length[7]}}, up_item.payload_length})
               + 10'sd1;
    hsum     = $signed({2'b00, hpoly}) + HSUM_W'(flen);
    hacc_nxt = hsum * flen;
  end

  // Stage two: (acc + f) * f with f = signed byte + 1, as magnitude and sign
  always_comb begin
    base = item2_r.start ? ACC_W'(hacc_r) : acc_r;
    fpay = $signed({{2{item2_r.payload_byte[7]}}, item2_r.payload_byte}) + 10'sd1;
    fneg = fpay[9];
    fmag = fneg ? 8'(-fpay) : fpay[7:0];
    sum  = base + ACC_W'(fpay);
    prod = sum * ACC_W'(fmag);
    if (item2_r.pay) begin
      acc_nxt = fneg ? (~prod + ACC_W'(1)) : prod;
    end else begin
      acc_nxt = base;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (s2_take) begin
        v2_r <= up_valid;
      end
      if (s3_take) begin
        v3_r <= v2_r;
      end
    end
  end

  // Stage data; acc_r doubles as the running accumulator
  always_ff @(posedge clk) begin
    if (s2_take && up_valid) begin
      item2_r <= up_item;
      hacc_r  <= hacc_nxt;
    end
    if (s3_take && v2_r) begin
      item3_r <= item2_r;
      acc_r   <= acc_nxt;
    end
  end

endmodule

// File: src/fce_emitter.sv
// ---------------------------------------------------------------------------
// fce_emitter
// Result register and byte sequencer: folds the accumulator into the checksum word
// and emits header, payload and checksum bytes one per cycle while not stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fce_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  fce_pkg::acc_item_t up_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_kind,
  output logic               run_last,
  output logic               frame_end
);

  localparam int WORD_W = fce_pkg::WORD_W;

  // Byte slots of one item's result run
  localparam logic [3:0] SLOT_MAGIC_A = 4'd0;
  localparam logic [3:0] SLOT_MAGIC_B = 4'd1;
  localparam logic [3:0] SLOT_VERSION = 4'd2;
  localparam logic [3:0] SLOT_TYPE    = 4'd3;
  localparam logic [3:0] SLOT_LEN     = 4'd4;
  localparam logic [3:0] SLOT_PAY     = 4'd5;
  localparam logic [3:0] SLOT_CHK0    = 4'd6;
  localparam logic [3:0] SLOT_LAST    = 4'd13;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic [7:0]        payload_length;
    logic              pay;
    logic              ends;
    logic [WORD_W-1:0] word;
  } job_t;

  // Even accumulator bits, then one low-to-high swap pass. The skip flag is
  // a single-gate chain per bit, comparable to a ripple carry.
  function automatic logic [WORD_W-1:0] fold_word(input logic [fce_pkg::ACC_W-1:0] acc);
    logic [WORD_W-1:0] w;
    logic              skip;
    for (int k = 0; k < WORD_W; k++) begin
      w[k] = acc[2*k];
    end
    skip = 1'b0;
    for (int i = 0; i < WORD_W - 1; i++) begin
      if (!skip && !w[i]) begin
        if (w[i+1]) begin
          w[i]   = 1'b1;
          w[i+1] = 1'b0;
        end
        skip = 1'b1;
      end else begin
        skip = 1'b0;
      end
    end
    return w;
  endfunction

  logic              valid_r;
  job_t              job_r, job_nxt;
  logic [3:0]        slot_r, slot_nxt, slot_first;
  logic              last, load, fire;
  logic [WORD_W-1:0] rev;
  logic [2:0]        chk_idx;
  logic [63:0]       chk_bytes;
  logic [7:0]        chk_byte;

  assign last     = (slot_r == SLOT_PAY && !job_r.ends) || (slot_r == SLOT_LAST);
  assign fire     = valid_r && out_ready;
  assign up_ready = !valid_r || (out_ready && last);
  assign load     = up_ready && up_valid;

  // Next job and its first slot
  always_comb begin
    job_nxt.payload_byte   = up_data.item.payload_byte;
    job_nxt.payload_length = up_data.item.payload_length;
    job_nxt.pay            = up_data.item.pay;
    job_nxt.ends           = up_data.item.ends;
    job_nxt.word           = fold_word(up_data.acc);
    slot_first = up_data.item.start ? SLOT_MAGIC_A : SLOT_PAY;
    if (slot_r == SLOT_LEN) begin
      slot_nxt = job_r.pay ? SLOT_PAY : SLOT_CHK0;
    end else begin
      slot_nxt = slot_r + 4'd1;
    end
  end

  // Checksum bytes: word little-endian, then its bit reversal
  always_comb begin
    for (int k = 0; k < WORD_W; k++) begin
      rev[k] = job_r.word[WORD_W-1-k];
    end
    chk_idx   = 3'(slot_r - SLOT_CHK0);
    chk_bytes = {rev, job_r.word};
    chk_byte  = chk_bytes[{chk_idx, 3'b000} +: 8];
  end

  // Output payload
  always_comb begin
    unique case (slot_r)
      SLOT_MAGIC_A: out_byte = fce_pkg::MAGIC_A;
      SLOT_MAGIC_B: out_byte = fce_pkg::MAGIC_B;
      SLOT_VERSION: out_byte = fce_pkg::FRAME_VERSION;
      SLOT_TYPE:    out_byte = fce_pkg::FRAME_TYPE;
      SLOT_LEN:     out_byte = job_r.payload_length;
      SLOT_PAY:     out_byte = job_r.payload_byte;
      default:      out_byte = chk_byte;
    endcase
    priority if (slot_r < SLOT_PAY) begin
      out_kind = fce_pkg::KIND_HEADER;
    end else if (slot_r == SLOT_PAY) begin
      out_kind = fce_pkg::KIND_PAYLOAD;
    end else begin
      out_kind = fce_pkg::KIND_CHECK;
    end
    out_valid = valid_r;
    run_last  = last;
    frame_end = (slot_r == SLOT_LAST);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= SLOT_MAGIC_A;
    end else begin
      if (up_ready) begin
        valid_r <= up_valid;
      end
      if (load) begin
        slot_r <= slot_first;
      end else if (fire && !last) begin
        slot_r <= slot_nxt;
      end
    end
  end

  // Job register
  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_nxt;
    end
  end

endmodule

// File: src/fce_checker.sv
// ---------------------------------------------------------------------------
// fce_checker
// Port-level checks on the result stream of the encoder, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fce_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       run_last,
  input logic       frame_end
);

  // Frame end is always the closing checksum byte of its transaction
  `FCE_ASSERT_IMPL(a_end_is_last, clk, rst_n, out_valid && frame_end, run_last && out_kind == fce_pkg::KIND_CHECK)

  // A header byte is never the last result of a transaction
  `FCE_ASSERT_IMPL(a_hdr_not_last, clk, rst_n, out_valid && out_kind == fce_pkg::KIND_HEADER, !run_last)

  // A run of results continues without gaps once started
  `FCE_ASSERT_NEXT(a_run_no_gap, clk, rst_n, out_valid && out_ready && !run_last, out_valid)

  // A stalled result holds
  `FCE_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_kind))

endmodule

bind framed_checksum_encoder fce_checker u_fce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .out_kind  (out_chan.out_kind),
  .run_last  (out_chan.run_last),
  .frame_end (out_chan.frame_end)
);

// File: dv/framed_checksum_encoder_tb.sv
// ---------------------------------------------------------------------------
// framed_checksum_encoder_tb
// Streams payload bytes through the frame encoder with random source gaps and
// sink stalls. A local frame builder predicts every header, payload and
// checksum byte, and each result is checked in order against it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_checksum_encoder_tb;

  localparam int IDLE_LIMIT = 1000;  // cycles with no transaction on either side
  localparam int DRAIN_WAIT = 20;    // cycles after the last expected byte
  localparam int RANDOM_ITEMS = 160;

  // One input transaction
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] len;
  } src_word_t;

  // One emitted frame byte
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       run_last;
    logic       frame_end;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  fce_in_if  in_chan ();
  fce_out_if out_chan ();

  framed_checksum_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  src_word_t   src_q[$];
  frame_byte_t frame_q[$];

  // Frame builder state
  logic [63:0] frame_acc   = '0;
  logic [7:0]  bytes_left  = '0;
  logic        frame_open  = 1'b0;

  int  mismatches  = 0;
  int  idle_cycles = 0;
  logic in_taken   = 1'b0;
  logic out_taken  = 1'b0;
  int  in_gap      = 0;
  int  out_wait    = 0;
  bit  in_calm     = 1'b0;
  bit  out_calm    = 1'b0;
  src_word_t next_word;

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 7));
  endfunction

  // Even accumulator bits, then the low-to-high swap pass over bits 0..30
  function automatic logic [31:0] fold_checksum(input logic [63:0] acc);
    logic [31:0] w;
    int i;
    for (i = 0; i < 32; i++) w[i] = acc[2*i];
    i = 0;
    while (i < 31) begin
      if (!w[i]) begin
        if (w[i+1]) begin
          w[i]   = 1'b1;
          w[i+1] = 1'b0;
        end
        i = i + 2;
      end else begin
        i = i + 1;
      end
    end
    return w;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic [1:0] kind);
    frame_byte_t fb;
    fb = '{data: b, kind: kind, run_last: 1'b0, frame_end: 1'b0};
    frame_q.insert(frame_q.size(), fb);
  endtask

  // Header and payload bytes feed the accumulator as signed values
  task automatic absorb_byte(input logic [7:0] b, input logic [1:0] kind);
    logic [63:0] f;
    f = {{56{b[7]}}, b} + 64'd1;
    frame_acc = (frame_acc + f) * f;
    push_byte(b, kind);
  endtask

  task automatic close_frame();
    logic [31:0] w;
    logic [31:0] rev;
    int i;
    w = fold_checksum(frame_acc);
    for (i = 0; i < 32; i++) rev[i] = w[31-i];
    for (i = 0; i < 4; i++) push_byte(w[8*i +: 8], fce_pkg::KIND_CHECK);
    for (i = 0; i < 4; i++) push_byte(rev[8*i +: 8], fce_pkg::KIND_CHECK);
    frame_q[frame_q.size() - 1].frame_end = 1'b1;
    frame_open = 1'b0;
    bytes_left = '0;
  endtask

  // Expected bytes for one accepted transaction
  task automatic encode_word(input src_word_t sw);
    if (!frame_open) begin
      frame_acc = 64'(fce_pkg::HEADER_LEN) + 64'(sw.len);
      absorb_byte(fce_pkg::MAGIC_A, fce_pkg::KIND_HEADER);
      absorb_byte(fce_pkg::MAGIC_B, fce_pkg::KIND_HEADER);
      absorb_byte(fce_pkg::FRAME_VERSION, fce_pkg::KIND_HEADER);
      absorb_byte(fce_pkg::FRAME_TYPE, fce_pkg::KIND_HEADER);
      absorb_byte(sw.len, fce_pkg::KIND_HEADER);
      if (sw.len == 8'd0) begin
        close_frame();
      end else begin
        frame_open = 1'b1;
        bytes_left = sw.len;
      end
    end
    if (frame_open) begin
      absorb_byte(sw.data, fce_pkg::KIND_PAYLOAD);
      bytes_left = bytes_left - 8'd1;
      if (bytes_left == 8'd0) close_frame();
    end
    frame_q[frame_q.size() - 1].run_last = 1'b1;
  endtask

  task automatic note_mismatch(input string what, input frame_byte_t want,
                               input frame_byte_t got);
    if (mismatches < 10)
      $display("%0t: %s: expected byte %02h kind %0d last %0b end %0b, %s",
               $realtime, what, want.data, want.kind, want.run_last, want.frame_end,
               $sformatf("got byte %02h kind %0d last %0b end %0b",
                         got.data, got.kind, got.run_last, got.frame_end));
    mismatches++;
  endtask

  // Stimulus helpers
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_word(input logic [7:0] data, input logic [7:0] len);
    src_word_t sw;
    sw = '{data: data, len: len};
    src_q.insert(src_q.size(), sw);
  endtask

  // Mid-frame lengths are random since the block ignores them
  task automatic add_frame(input logic [7:0] len);
    int k;
    add_word(pick_byte(), len);
    for (k = 1; k < len; k++) add_word(pick_byte(), 8'($urandom_range(0, 255)));
  endtask

  // Source side: one transaction per item, random gap after each
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (in_gap != 0) begin
        in_chan.valid <= 1'b0;
        in_gap--;
      end else if (src_q.size() != 0) begin
        next_word = src_q.pop_front();
        in_chan.valid          <= 1'b1;
        in_chan.payload_byte   <= next_word.data;
        in_chan.payload_length <= next_word.len;
        if ($urandom_range(0, 23) == 0) in_calm = !in_calm;
        in_gap = draw_wait(in_calm);
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Sink side: random stall before each result
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 23) == 0) out_calm = !out_calm;
        out_wait = draw_wait(out_calm);
      end
      if (out_wait != 0) begin
        out_chan.ready <= 1'b0;
        out_wait--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Check results against the oldest expectation, then predict new input
  always @(posedge clk) begin
    frame_byte_t got;
    in_taken  <= rst_n && in_chan.valid && in_chan.ready;
    out_taken <= rst_n && out_chan.valid && out_chan.ready;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{data: out_chan.out_byte, kind: out_chan.out_kind,
              run_last: out_chan.run_last, frame_end: out_chan.frame_end};
      if (frame_q.size() == 0)
        note_mismatch("unexpected result", '0, got);
      else if (got !== frame_q[0]) begin
        note_mismatch("result mismatch", frame_q[0], got);
        void'(frame_q.pop_front());
      end else
        void'(frame_q.pop_front());
    end
    if (rst_n && in_chan.valid && in_chan.ready)
      encode_word('{data: in_chan.payload_byte, len: in_chan.payload_length});
  end

  // Watchdog on a stalled handshake
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[framed_checksum_encoder] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int produced;
    logic [7:0] len;
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.payload_byte   = '0;
    in_chan.payload_length = '0;
    out_chan.ready         = 1'b0;

    // Directed: empty frames, single-byte frames, sign boundaries, ignored fields
    add_word(8'hFF, 8'd0);
    add_word(8'h00, 8'd0);
    add_word(8'h80, 8'd1);
    add_word(8'hFF, 8'd1);
    add_word(8'h7F, 8'd1);
    add_word(8'h00, 8'd2);
    add_word(8'h01, 8'hFF);
    add_word(8'hFE, 8'd3);
    add_word(8'h81, 8'h00);
    add_word(8'h55, 8'hAA);
    add_frame(8'd4);

    // Random frames, mostly short, a few longer ones
    produced = 0;
    while (produced < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) len = 8'($urandom_range(16, 40));
      else                            len = 8'($urandom_range(0, 12));
      add_frame(len);
      produced += (len == 8'd0) ? 1 : int'(len);
    end
    // Largest length field (negative as a signed header byte); the frame is
    // left open after a few payload bytes
    add_word(pick_byte(), 8'hFF);
    repeat (3) add_word(pick_byte(), 8'($urandom_range(0, 255)));

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (src_q.size() != 0 || in_chan.valid) @(posedge clk);
    while (frame_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (mismatches == 0)
      $display("[framed_checksum_encoder] OK");
    else
      $display("[framed_checksum_encoder] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/fce_pkg.sv
src/fce_if.sv
src/fce_frame_ctl.sv
src/fce_checksum.sv
src/fce_emitter.sv
src/framed_checksum_encoder.sv
src/fce_checker.sv
dv/framed_checksum_encoder_tb.sv
